// ===== rtl/core/luhn_card_number_checker_unit_assert.svh =====
// assertion macros for the card number checker
// no dependencies; included inside module bodies that check their own logic
`ifndef LUHN_CARD_NUMBER_CHECKER_UNIT_ASSERT_SVH
`define LUHN_CARD_NUMBER_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LUHN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("luhn checker: same-cycle check failed");

// next-cycle implication, disabled during reset
`define LUHN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("luhn checker: next-cycle check failed");

`endif

// ===== rtl/core/luhn_pkg.sv =====
// shared types, constants and digit functions of the card number checker
// no dependencies
`default_nettype none

package luhn_pkg;

   // digit count limits
   localparam logic [4:0] SAT_COUNT = 5'd20;
   localparam logic [4:0] MIN_LEN   = 5'd13;
   localparam logic [4:0] MAX_LEN   = 5'd19;
   localparam logic [4:0] LEN_13    = 5'd13;
   localparam logic [4:0] LEN_15    = 5'd15;
   localparam logic [4:0] LEN_16    = 5'd16;
   localparam logic [4:0] LEN_TWO   = 5'd2;

   // ascii digit range
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_NINE = 8'h39;

   // card type codes
   localparam logic [2:0] CARD_UNKNOWN = 3'd0;
   localparam logic [2:0] CARD_PFX_3X  = 3'd1;
   localparam logic [2:0] CARD_PFX_5X  = 3'd2;
   localparam logic [2:0] CARD_LEAD_4  = 3'd3;
   localparam logic [2:0] CARD_PFX_60  = 3'd4;

   // input item
   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } char_item_type;

   // result item
   typedef struct packed {
      logic       valid_res;
      logic [2:0] card_type;
      logic [4:0] digit_count;
   } result_type;

   // input stage status toward the accumulator
   typedef struct packed {
      logic valid;
      logic fire;
   } stage_status_type;

   // doubled digit with the digit-sum fold
   function automatic logic [3:0] dbl_digit(input logic [3:0] d);
      logic [4:0] v;
      v = {d, 1'b0};
      if (v > 5'd9) begin
         v = v - 5'd9;
      end
      return v[3:0];
   endfunction

   // sum of two values below ten, mod 10
   function automatic logic [3:0] add_mod10(input logic [3:0] a, input logic [3:0] b);
      logic [4:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s > 5'd9) begin
         s = s - 5'd10;
      end
      return s[3:0];
   endfunction

   // card type from the first two digits and the digit count
   function automatic logic [2:0] card_type_of(input logic [3:0] first,
                                               input logic [3:0] second,
                                               input logic [4:0] cnt);
      logic [2:0] t;
      t = CARD_UNKNOWN;
      if (cnt < LEN_TWO) begin
         t = CARD_UNKNOWN;
      end else if (first == 4'd3 && (second == 4'd4 || second == 4'd7)) begin
         t = (cnt == LEN_15) ? CARD_PFX_3X : CARD_UNKNOWN;
      end else if (first == 4'd5 && second >= 4'd1 && second <= 4'd5) begin
         t = (cnt == LEN_16) ? CARD_PFX_5X : CARD_UNKNOWN;
      end else if (first == 4'd4) begin
         t = (cnt == LEN_13 || cnt == LEN_16) ? CARD_LEAD_4 : CARD_UNKNOWN;
      end else if (first == 4'd6 && second == 4'd0) begin
         t = (cnt >= LEN_16 && cnt <= MAX_LEN) ? CARD_PFX_60 : CARD_UNKNOWN;
      end
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/luhn_ifs.sv =====
// valid/ready channel interfaces for card characters and check results
// depends on luhn_pkg
`default_nettype none

interface luhn_req_if;
   import luhn_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last;
   modport source(output valid, output char_code, output last, input ready);
   modport sink(input valid, input char_code, input last, output ready);
endinterface

interface luhn_rsp_if;
   import luhn_pkg::*;
   logic       valid;
   logic       ready;
   logic       valid_res;
   logic [2:0] card_type;
   logic [4:0] digit_count;
   modport source(output valid, output valid_res, output card_type, output digit_count,
                  input ready);
   modport sink(input valid, input valid_res, input card_type, input digit_count,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/luhn_in_stage.sv =====
// input register for one character item and its advance control
// depends on luhn_pkg
`default_nettype none

module luhn_in_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  luhn_pkg::char_item_type      req_item,
   input  logic                         out_free,
   output luhn_pkg::char_item_type      stage_item,
   output luhn_pkg::stage_status_type   stage_status
);
   import luhn_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   char_item_type item_ff;
   logic          fire;

   // a non-last item never needs the output register
   assign fire      = valid_ff && (!item_ff.last || out_free);
   assign req_ready = !valid_ff || fire;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= req_item;
      end
   end

   assign stage_item         = item_ff;
   assign stage_status.valid = valid_ff;
   assign stage_status.fire  = fire;

endmodule

`default_nettype wire

// ===== rtl/core/luhn_accum.sv =====
// running luhn sums, digit count and prefix digits; forms the result item
// depends on luhn_pkg
`default_nettype none

module luhn_accum (
   input  logic                         clock,
   input  logic                         reset,
   input  luhn_pkg::char_item_type      stage_item,
   input  luhn_pkg::stage_status_type   stage_status,
   output luhn_pkg::result_type         result
);
   import luhn_pkg::*;

   logic [3:0] sum_even_ff, sum_even_in, sum_even_upd;
   logic [3:0] sum_odd_ff,  sum_odd_in,  sum_odd_upd;
   logic [4:0] count_ff,    count_in,    count_upd;
   logic [3:0] first_ff,    first_in,    first_upd;
   logic [3:0] second_ff,   second_in,   second_upd;
   logic       is_digit;
   logic       take;
   logic [3:0] digit;
   logic [3:0] digit_dbl;
   logic [3:0] sum_sel;

   // digit detect and decode
   assign is_digit  = stage_item.char_code >= ASCII_ZERO && stage_item.char_code <= ASCII_NINE;
   assign digit     = stage_item.char_code[3:0];
   assign digit_dbl = dbl_digit(digit);
   assign take      = is_digit && (count_ff < SAT_COUNT);

   // state after taking this character
   always_comb begin
      sum_even_upd = sum_even_ff;
      sum_odd_upd  = sum_odd_ff;
      count_upd    = count_ff;
      first_upd    = first_ff;
      second_upd   = second_ff;
      if (take) begin
         if (count_ff[0]) begin
            sum_even_upd = add_mod10(sum_even_ff, digit);
            sum_odd_upd  = add_mod10(sum_odd_ff, digit_dbl);
         end else begin
            sum_even_upd = add_mod10(sum_even_ff, digit_dbl);
            sum_odd_upd  = add_mod10(sum_odd_ff, digit);
         end
         count_upd = count_ff + 5'd1;
         if (count_ff == 5'd0) begin
            first_upd = digit;
         end
         if (count_ff == 5'd1) begin
            second_upd = digit;
         end
      end
   end

   // result from the updated state
   assign sum_sel            = count_upd[0] ? sum_odd_upd : sum_even_upd;
   assign result.valid_res   = (count_upd >= MIN_LEN) && (count_upd <= MAX_LEN)
                               && (sum_sel == 4'd0);
   assign result.card_type   = card_type_of(first_upd, second_upd, count_upd);
   assign result.digit_count = count_upd;

   // commit on advance; the last item starts a fresh number
   always_comb begin
      sum_even_in = sum_even_ff;
      sum_odd_in  = sum_odd_ff;
      count_in    = count_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      if (stage_status.valid && stage_status.fire) begin
         if (stage_item.last) begin
            sum_even_in = 4'd0;
            sum_odd_in  = 4'd0;
            count_in    = 5'd0;
            first_in    = 4'd0;
            second_in   = 4'd0;
         end else begin
            sum_even_in = sum_even_upd;
            sum_odd_in  = sum_odd_upd;
            count_in    = count_upd;
            first_in    = first_upd;
            second_in   = second_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_even_ff <= 4'd0;
         sum_odd_ff  <= 4'd0;
         count_ff    <= 5'd0;
         first_ff    <= 4'd0;
         second_ff   <= 4'd0;
      end else begin
         sum_even_ff <= sum_even_in;
         sum_odd_ff  <= sum_odd_in;
         count_ff    <= count_in;
         first_ff    <= first_in;
         second_ff   <= second_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/luhn_out_stage.sv =====
// result register feeding the response channel
// depends on luhn_pkg
`default_nettype none

module luhn_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  luhn_pkg::result_type   result,
   output logic                   out_free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output luhn_pkg::result_type   rsp_result
);
   import luhn_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // free when empty or drained this cycle
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

// ===== rtl/core/luhn_card_number_checker_unit.sv =====
// the result of a last character is formed while it sits in the input register and is then held in the result register
// throughput: one character item per cycle; a last character waits in the input
// register while the result register holds an item that is not being taken
// the sum update is one mod-10 add between the input register and result register
// reset: synchronous, active high; clears sums, count, prefix digits and valid flags
// depends on luhn_pkg, luhn_ifs, luhn_in_stage, luhn_accum, luhn_out_stage, luhn_card_number_checker_unit_assert.svh
`default_nettype none

module luhn_card_number_checker_unit (
   input  logic        clock,
   input  logic        reset,
   luhn_req_if.sink    req_chan,
   luhn_rsp_if.source  rsp_chan
);
   import luhn_pkg::*;

   char_item_type    req_item;
   char_item_type    stage_item;
   stage_status_type stage_status;
   result_type       result;
   result_type       rsp_result;
   logic             out_free;
   logic             load;

   assign req_item.char_code = req_chan.char_code;
   assign req_item.last      = req_chan.last;

   // input register
   luhn_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .req_item     (req_item),
      .out_free     (out_free),
      .stage_item   (stage_item),
      .stage_status (stage_status)
   );

   // checksum state and result logic
   luhn_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .stage_item   (stage_item),
      .stage_status (stage_status),
      .result       (result)
   );

   // only the last character of a number yields an item
   assign load = stage_status.valid && stage_status.fire && stage_item.last;

   // result register
   luhn_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .result     (result),
      .out_free   (out_free),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_result (rsp_result)
   );

   assign rsp_chan.valid_res   = rsp_result.valid_res;
   assign rsp_chan.card_type   = rsp_result.card_type;
   assign rsp_chan.digit_count = rsp_result.digit_count;

   // checks
`include "luhn_card_number_checker_unit_assert.svh"

   `LUHN_ASSERT_NEXT(a_load_gives_item, clock, reset, load, rsp_chan.valid)
   `LUHN_ASSERT_NOW(a_valid_len, clock, reset, rsp_chan.valid && rsp_chan.valid_res,
                    rsp_chan.digit_count >= MIN_LEN && rsp_chan.digit_count <= MAX_LEN)
   `LUHN_ASSERT_NOW(a_load_needs_room, clock, reset, load, out_free)

endmodule

`default_nettype wire
